// ----- rtl/arp_resp_pkg.sv -----
// Shared types, constants and the frame byte builder of the ARP responder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package arp_resp_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 1518;
    localparam int COUNT_W             = 11;
    localparam int MAC_W               = 48;
    localparam int IP_W                = 32;
    localparam int CFG_DATA_W          = 48;
    localparam int CFG_INDEX_W         = 2;

    localparam int ARP_FRAME_LEN = 14 + 28;
    localparam int ARP_BODY_LEN  = 28;
    localparam int FRAME_BITS    = ARP_FRAME_LEN * 8;
    localparam int BYTE_IDX_W    = $clog2(ARP_FRAME_LEN);
    localparam int BIT_IDX_W     = $clog2(FRAME_BITS);

    localparam int JOB_DEPTH = 4;

    localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [7:0]  ARP_HLEN       = 8'd6;
    localparam logic [7:0]  ARP_PLEN       = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

    localparam logic [MAC_W-1:0] PEER_MAC_RESET = '1;
    localparam logic [IP_W-1:0]  PEER_IP_RESET  = '0;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_IP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PEER_MAC = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PEER_IP  = 2'd3;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_LEARN = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       rx_last;
    } arp_in_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       tx_byte;
        logic             tx_last;
        logic [MAC_W-1:0] learned_mac;
        logic [IP_W-1:0]  learned_ip;
    } arp_out_t;

    // A learned address, an ARP reply to a requester or an ARP request to the peer.
    typedef struct packed {
        logic             is_learn;
        logic             is_reply;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } arp_job_t;

    function automatic logic [7:0] arp_frame_byte(
        input logic [BYTE_IDX_W-1:0] idx,
        input logic [MAC_W-1:0]      own_mac,
        input logic [IP_W-1:0]       own_ip,
        input arp_job_t              job
    );
        logic [FRAME_BITS-1:0] frame;
        logic [15:0]           op;
        logic [MAC_W-1:0]      tgt_mac;
        logic [BIT_IDX_W-1:0]  base;
        op      = job.is_reply ? ARP_OP_REPLY : ARP_OP_REQUEST;
        tgt_mac = job.is_reply ? job.mac : '0;
        frame   = {job.mac, own_mac, ETH_TYPE_ARP, ARP_HTYPE_ETH, ETH_TYPE_IPV4,
                   ARP_HLEN, ARP_PLEN, op, own_mac, own_ip, tgt_mac, job.ip};
        base    = BIT_IDX_W'({BYTE_IDX_W'(ARP_FRAME_LEN - 1) - idx, 3'b000});
        return frame[base +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/arp_responder_core.sv -----
// Top level of the ARP responder: receive front end, job queue and transmit back end.
// Depends on arp_resp_pkg, arp_resp_front, arp_resp_fifo and arp_resp_back.
//
// The block takes one received byte or send command per cycle and produces output
// transactions through a registered output stage. A received ARP reply yields one
// learned-address transaction; a received ARP request or a send command yields a
// 42-byte frame, one byte per cycle while the output is not stalled, once the job
// has been loaded from a four-entry queue. The input is stalled only while that
// queue is full, which happens when frame jobs arrive faster than the transmit side
// can send them or while the output is held stalled. There is no clearing pass after
// reset.
`default_nettype none

module arp_responder_core #(
    parameter int MAX_FRAME_BYTES = arp_resp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire arp_resp_pkg::arp_in_t           in_data,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output arp_resp_pkg::arp_out_t               out_data,
    input  wire                                  cfg_we,
    input  wire [arp_resp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [arp_resp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                   push, full, pop, avail;
    arp_resp_pkg::arp_job_t push_job, pop_job;

    arp_resp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    arp_resp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .full    (full),
        .pop     (pop),
        .pop_job (pop_job),
        .avail   (avail)
    );

    arp_resp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .avail    (avail),
        .job      (pop_job),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ----- rtl/arp_resp_front.sv -----
// Receive side of the ARP responder: captures header fields, judges frames,
// keeps the peer address and issues jobs. Depends on arp_resp_pkg.
`default_nettype none

module arp_resp_front #(
    parameter int MAX_FRAME_BYTES = arp_resp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    input  wire arp_resp_pkg::arp_in_t              in_data,
    output logic                                    in_stall,
    input  wire                                     cfg_we,
    input  wire [arp_resp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [arp_resp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                    push,
    output arp_resp_pkg::arp_job_t                  push_job,
    input  wire                                     full
);

    localparam int CW = arp_resp_pkg::COUNT_W;
    localparam logic [CW-1:0] MAX_CNT     = CW'(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] LAST_MIN    = CW'(arp_resp_pkg::ARP_FRAME_LEN - 1);
    localparam logic [CW-1:0] OFF_TYPE    = CW'(12);
    localparam logic [CW-1:0] OFF_OPCODE  = CW'(20);
    localparam logic [CW-1:0] OFF_SMAC    = CW'(22);
    localparam logic [CW-1:0] OFF_SMAC_Z  = CW'(27);
    localparam logic [CW-1:0] OFF_SIP     = CW'(28);
    localparam logic [CW-1:0] OFF_SIP_Z   = CW'(31);

    logic [CW-1:0]                       count_reg, count_next;
    logic [15:0]                         type_reg, type_next;
    logic [15:0]                         opcode_reg, opcode_next;
    logic [arp_resp_pkg::MAC_W-1:0]      smac_reg, smac_next;
    logic [arp_resp_pkg::IP_W-1:0]       sip_reg, sip_next;
    logic [arp_resp_pkg::MAC_W-1:0]      peer_mac_reg, peer_mac_next;
    logic [arp_resp_pkg::IP_W-1:0]       peer_ip_reg, peer_ip_next;
    logic                                accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_comb
    begin
        count_next    = count_reg;
        type_next     = type_reg;
        opcode_next   = opcode_reg;
        smac_next     = smac_reg;
        sip_next      = sip_reg;
        peer_mac_next = peer_mac_reg;
        peer_ip_next  = peer_ip_reg;
        push          = 1'b0;
        push_job      = '{is_learn: 1'b0, is_reply: 1'b0, mac: peer_mac_reg, ip: peer_ip_reg};

        if (accept)
        begin
            if (in_data.command)
            begin
                push = 1'b1;
            end
            else
            begin
                if (count_reg == OFF_TYPE || count_reg == OFF_TYPE + CW'(1))
                begin
                    type_next = {type_reg[7:0], in_data.rx_byte};
                end
                else if (count_reg == OFF_OPCODE || count_reg == OFF_OPCODE + CW'(1))
                begin
                    opcode_next = {opcode_reg[7:0], in_data.rx_byte};
                end
                else if (count_reg >= OFF_SMAC && count_reg <= OFF_SMAC_Z)
                begin
                    smac_next = {smac_reg[arp_resp_pkg::MAC_W-9:0], in_data.rx_byte};
                end
                else if (count_reg >= OFF_SIP && count_reg <= OFF_SIP_Z)
                begin
                    sip_next = {sip_reg[arp_resp_pkg::IP_W-9:0], in_data.rx_byte};
                end

                if (count_reg < MAX_CNT)
                begin
                    count_next = count_reg + CW'(1);
                end

                if (in_data.rx_last)
                begin
                    // A frame long enough to judge has no captured field in its last byte.
                    if (type_reg == arp_resp_pkg::ETH_TYPE_ARP && count_reg >= LAST_MIN)
                    begin
                        if (opcode_reg == arp_resp_pkg::ARP_OP_REPLY)
                        begin
                            push          = 1'b1;
                            push_job      = '{is_learn: 1'b1, is_reply: 1'b0,
                                              mac: smac_reg, ip: sip_reg};
                            peer_mac_next = smac_reg;
                            peer_ip_next  = sip_reg;
                        end
                        else if (opcode_reg == arp_resp_pkg::ARP_OP_REQUEST)
                        begin
                            push     = 1'b1;
                            push_job = '{is_learn: 1'b0, is_reply: 1'b1,
                                         mac: smac_reg, ip: sip_reg};
                        end
                    end
                    count_next  = '0;
                    type_next   = '0;
                    opcode_next = '0;
                    smac_next   = '0;
                    sip_next    = '0;
                end
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                arp_resp_pkg::REG_PEER_MAC: peer_mac_next = cfg_data;
                arp_resp_pkg::REG_PEER_IP:  peer_ip_next  = cfg_data[arp_resp_pkg::IP_W-1:0];
                arp_resp_pkg::REG_OWN_MAC,
                arp_resp_pkg::REG_OWN_IP:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            type_reg     <= '0;
            opcode_reg   <= '0;
            smac_reg     <= '0;
            sip_reg      <= '0;
            peer_mac_reg <= arp_resp_pkg::PEER_MAC_RESET;
            peer_ip_reg  <= arp_resp_pkg::PEER_IP_RESET;
        end
        else
        begin
            count_reg    <= count_next;
            type_reg     <= type_next;
            opcode_reg   <= opcode_next;
            smac_reg     <= smac_next;
            sip_reg      <= sip_next;
            peer_mac_reg <= peer_mac_next;
            peer_ip_reg  <= peer_ip_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/arp_resp_fifo.sv -----
// Short job queue between the receive side and the transmit side.
// Depends on arp_resp_pkg for the job type and depth.
`default_nettype none

module arp_resp_fifo (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              push,
    input  wire arp_resp_pkg::arp_job_t      push_job,
    output logic                             full,
    input  wire                              pop,
    output arp_resp_pkg::arp_job_t           pop_job,
    output logic                             avail
);

    localparam int DEPTH = arp_resp_pkg::JOB_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    arp_resp_pkg::arp_job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign full    = fill_reg == CW'(DEPTH);
    assign avail   = fill_reg != '0;
    assign pop_job = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/arp_resp_back.sv -----
// Transmit side of the ARP responder: holds this station's addresses and turns
// queued jobs into output transactions. Depends on arp_resp_pkg.
`default_nettype none

module arp_resp_back (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire [arp_resp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [arp_resp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                                  avail,
    input  wire arp_resp_pkg::arp_job_t          job,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output arp_resp_pkg::arp_out_t               out_data
);

    localparam int IW = arp_resp_pkg::BYTE_IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(arp_resp_pkg::ARP_FRAME_LEN - 1);

    logic [arp_resp_pkg::MAC_W-1:0] own_mac_reg, own_mac_next;
    logic [arp_resp_pkg::IP_W-1:0]  own_ip_reg, own_ip_next;
    logic                           active_reg, active_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    arp_resp_pkg::arp_job_t         cur_reg, cur_next;
    logic                           out_valid_reg, out_valid_next;
    arp_resp_pkg::arp_out_t         out_data_reg, out_data_next;
    logic                           advance;

    assign advance   = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        own_mac_next   = own_mac_reg;
        own_ip_next    = own_ip_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b0;
            if (active_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{kind: arp_resp_pkg::KIND_TX,
                                   tx_byte: arp_resp_pkg::arp_frame_byte(idx_reg, own_mac_reg,
                                                                        own_ip_reg, cur_reg),
                                   tx_last: idx_reg == LAST_IDX,
                                   learned_mac: '0, learned_ip: '0};
                if (idx_reg == LAST_IDX)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            else if (avail)
            begin
                pop = 1'b1;
                if (job.is_learn)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{kind: arp_resp_pkg::KIND_LEARN, tx_byte: '0,
                                       tx_last: 1'b0, learned_mac: job.mac,
                                       learned_ip: job.ip};
                end
                else
                begin
                    cur_next    = job;
                    active_next = 1'b1;
                    idx_next    = '0;
                end
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                arp_resp_pkg::REG_OWN_MAC: own_mac_next = cfg_data;
                arp_resp_pkg::REG_OWN_IP:  own_ip_next  = cfg_data[arp_resp_pkg::IP_W-1:0];
                arp_resp_pkg::REG_PEER_MAC,
                arp_resp_pkg::REG_PEER_IP: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            own_mac_reg   <= own_mac_next;
            own_ip_reg    <= own_ip_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/arp_resp_checker.sv -----
// Port-level checks for the ARP responder and the bind that attaches them.
// Depends on arp_resp_pkg and arp_responder_core.
`default_nettype none

module arp_resp_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          out_valid,
    input wire                          out_stall,
    input wire arp_resp_pkg::arp_out_t  out_data
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled output transaction changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == arp_resp_pkg::KIND_TX |->
            out_data.learned_mac == '0 && out_data.learned_ip == '0)
        else $error("Transmit byte carries learned address bits.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == arp_resp_pkg::KIND_LEARN |->
            out_data.tx_byte == '0 && !out_data.tx_last)
        else $error("Learned-address transaction carries frame bits.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.kind == arp_resp_pkg::KIND_TX && !out_data.tx_last
            |=> out_valid && out_data.kind == arp_resp_pkg::KIND_TX)
        else $error("Outgoing frame was interrupted before its last byte.");

endmodule

bind arp_responder_core arp_resp_checker u_arp_resp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

`default_nettype wire
